/* rtl/bdq_pkg.sv */
package bdq_pkg;

  // Operation codes carried in the operation field
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 11;
  localparam int OCC_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Result fields computed at accept time; the word itself may come from the store
  typedef struct packed {
    logic              use_ram;
    logic [WORD_W-1:0] fixed_value;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } result_meta_t;

endpackage

/* rtl/bdq_ram.sv */
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bounded_double_ended_queue_core.sv */
// Bounded double-ended queue of signed 32-bit words.
//
// Input channel (in_valid/in_ready): one transaction carries an operation
// (push back, push front, pop front, pop back, peek front, peek back) and a
// value used by pushes. Output channel (out_valid/out_ready): one transaction
// per input transaction, in order, with read_value, status and occupancy.
// Configuration: cfg_we writes cfg_wdata into the capacity register in the
// same cycle; write it only while no transaction is in flight.
//
// Pointers and count update at accept and the store read issues in the same
// cycle, so one transaction per cycle is sustained while the receiver does not
// stall; a result passes through the pending stage, which holds it while the
// store read completes, and then through the output register.
//
// Reset empties the queue (head and count to zero) and sets capacity to 1024;
// store contents are not cleared, none is read before it is written.
// When the receiver stalls, the result waits in the output register while one
// more transaction is accepted into the pending stage; further input then
// waits until the output register drains.
module bounded_double_ended_queue_core #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   operation,
  input  logic signed [31:0]           value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           read_value,
  output logic [1:0]                   status,
  output logic [bdq_pkg::OCC_W-1:0]    occupancy
);

  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = AW + 1;
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  // Queue state
  logic [AW-1:0]    head_index, head_index_next;
  logic [CW-1:0]    entry_count, entry_count_next;
  logic [CAP_W-1:0] capacity;

  // Pending stage: holds a transaction while the store read completes
  logic         pend_valid;
  result_meta_t pend, pend_next;
  logic         pend_move;

  // Store port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic    accept;
  op_t     op;
  logic    is_full, is_empty;
  logic [PW-1:0] head_p, count_p, back_sum, tail_sum, front_inc;
  logic [AW-1:0] back_pos, tail_pos, front_dec, front_next;

  assign op        = op_t'(operation);
  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = !pend_valid || pend_move;
  assign accept    = in_valid && in_ready;

  assign is_full  = (XW'(entry_count) >= XW'(capacity)) || (XW'(entry_count) >= XW'(DEPTH));
  assign is_empty = (entry_count == '0);

  // Circular address arithmetic; every sum stays below twice DEPTH
  assign head_p    = {1'b0, head_index};
  assign count_p   = PW'(entry_count);
  assign tail_sum  = head_p + count_p;
  assign back_sum  = head_p + count_p - PW'(1);
  assign front_inc = head_p + PW'(1);
  assign tail_pos  = (tail_sum >= PW'(DEPTH)) ? AW'(tail_sum - PW'(DEPTH)) : AW'(tail_sum);
  assign back_pos  = (back_sum >= PW'(DEPTH)) ? AW'(back_sum - PW'(DEPTH)) : AW'(back_sum);
  assign front_next = (front_inc >= PW'(DEPTH)) ? '0 : AW'(front_inc);
  assign front_dec = (head_index == '0) ? AW'(DEPTH - 1) : head_index - AW'(1);

  always_comb begin
    head_index_next       = head_index;
    entry_count_next      = entry_count;
    ram_we                = 1'b0;
    ram_re                = 1'b0;
    ram_waddr             = tail_pos;
    ram_raddr             = head_index;
    pend_next.use_ram     = 1'b0;
    pend_next.fixed_value = '0;
    pend_next.status      = ST_OK;
    if (accept) begin
      unique case (op)
        OP_PUSH_BACK: begin
          if (is_full) begin
            pend_next.status = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = tail_pos;
            entry_count_next = entry_count + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            pend_next.status = ST_FULL;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = front_dec;
            head_index_next  = front_dec;
            entry_count_next = entry_count + CW'(1);
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (is_empty) begin
            pend_next.status      = ST_EMPTY;
            pend_next.fixed_value = '1;
          end else begin
            ram_re            = 1'b1;
            ram_raddr         = head_index;
            pend_next.use_ram = 1'b1;
            if (op == OP_POP_FRONT) begin
              head_index_next  = front_next;
              entry_count_next = entry_count - CW'(1);
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (is_empty) begin
            pend_next.status      = ST_EMPTY;
            pend_next.fixed_value = '1;
          end else begin
            ram_re            = 1'b1;
            ram_raddr         = back_pos;
            pend_next.use_ram = 1'b1;
            if (op == OP_POP_BACK) begin
              entry_count_next = entry_count - CW'(1);
            end
          end
        end
        default: begin
          // Undefined codes: no change, report current count
        end
      endcase
    end
    pend_next.occupancy = OCC_W'(XW'(entry_count_next));
  end

  bdq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      head_index  <= head_index_next;
      entry_count <= entry_count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // Advance pending stage; hold it while the output register is stalled
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers; the store read data stays put until the next read
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
    if (pend_move) begin
      read_value <= pend.use_ram ? ram_rdata : pend.fixed_value;
      status     <= pend.status;
      occupancy  <= pend.occupancy;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(entry_count) <= XW'(DEPTH))
    else $error("entry count exceeds depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    PW'(head_index) < PW'(DEPTH))
    else $error("head index out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && !is_full
    |=> entry_count == $past(entry_count) + CW'(1))
    else $error("accepted push did not grow the count");

  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_move |-> !in_ready)
    else $error("input taken while pending stage is stalled");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_move |=> pend_valid && $stable(pend))
    else $error("stalled pending transaction changed");

endmodule

/* tb/bounded_double_ended_queue_core_tb.sv */
module bounded_double_ended_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int QUEUE_DEPTH = 1024;
  // Undefined operation codes: the block must leave its state alone
  localparam logic [2:0] OP_RESERVED_6 = 3'd6;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;
  // Receiver holds off this long at two points so the input side backs up
  localparam int HOLD_OFF_CYCLES = 60;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] val;
  } deque_request_t;

  typedef struct {
    logic signed [31:0] read_value;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;
  } deque_reply_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               operation = '0;
  logic signed [31:0]       value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       read_value;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;

  // Shadow copy of the deque: circular store, front pointer, count, capacity
  logic [31:0]              shadow_words [QUEUE_DEPTH];
  int                       shadow_head = 0;
  int                       shadow_count = 0;
  int                       shadow_capacity = int'(CAP_RESET);

  deque_request_t           request_backlog[$];
  deque_reply_t             awaited_replies[$];
  deque_request_t           next_req;
  deque_reply_t             want;
  int                       requests_queued = 0;
  int                       replies_checked = 0;
  int                       replies_seen = 0;
  int                       error_count = 0;
  int                       send_gap = 0;
  int                       stall_left = 0;
  int                       hold_off_left = 0;
  bit                       idle_on = 1'b0;

  bounded_double_ended_queue_core #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_value(read_value),
    .status    (status),
    .occupancy (occupancy)
  );

  always #2ns clk = ~clk;

  // Apply one operation to the shadow deque and return the reply it must produce.
  // Capacity above the store depth clamps to the depth; a capacity lowered under
  // the count keeps the stored words and just refuses pushes.
  function automatic deque_reply_t deque_apply(logic [2:0] op, logic signed [31:0] val);
    deque_reply_t r;
    int           limit;
    int           pos;
    r.read_value = '0;
    r.status     = ST_OK;
    limit = (shadow_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : shadow_capacity;
    case (op_t'(op))
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_count >= limit) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          shadow_words[(shadow_head + shadow_count) % QUEUE_DEPTH] = val;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          shadow_words[shadow_head] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.read_value = -32'sd1;
          r.status     = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
            pos = shadow_head;
          end else begin
            pos = (shadow_head + shadow_count - 1) % QUEUE_DEPTH;
          end
          r.read_value = shadow_words[pos];
          if (op == OP_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
            shadow_count--;
          end else if (op == OP_POP_BACK) begin
            shadow_count--;
          end
        end
      end
      default: begin
        // reserved codes: no state change, ok status, current count
      end
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  // Gap length: none while idling is off; else mostly none, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias data words toward the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ($urandom_range(0, 1) != 0) ? OP_RESERVED_7 : OP_RESERVED_6;
    if (r < 2 + push_pct) return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    case ($urandom_range(0, 5))
      0, 1:    return OP_POP_FRONT;
      2, 3:    return OP_POP_BACK;
      4:       return OP_PEEK_FRONT;
      default: return OP_PEEK_BACK;
    endcase
  endfunction

  task automatic queue_request(logic [2:0] op, logic [31:0] val);
    deque_request_t req;
    req.op  = op;
    req.val = val;
    request_backlog.push_back(req);
    requests_queued++;
  endtask

  // Block until every queued request has come back, then let the pipe settle
  task automatic wait_drained();
    while (replies_checked != requests_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity may change only with nothing in flight
  task automatic set_capacity(int cap);
    wait_drained();
    cfg_we          <= 1'b1;
    cfg_wdata       <= cap[CAP_W-1:0];
    shadow_capacity = cap;
    @(posedge clk);
    cfg_we          <= 1'b0;
  endtask

  task automatic random_phase(int cap, bit idle, int n_items, int push_pct);
    set_capacity(cap);
    idle_on = idle;
    repeat (n_items) queue_request(pick_op(push_pct), pick_word());
  endtask

  // Driver: present the next request from the backlog; hold it until accepted.
  // The shadow deque advances on the accepting edge, so predictions follow
  // the exact order the block sees.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        awaited_replies.push_back(deque_apply(operation, value));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        next_req = request_backlog.pop_front();
        in_valid  <= 1'b1;
        operation <= next_req.op;
        value     <= next_req.val;
        send_gap  = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs: count output transactions and hold-off cycles here
  always @(posedge clk) begin
    if (rst) begin
      replies_seen  <= 0;
      hold_off_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen <= replies_seen + 1;
      end
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
      end else if (out_valid && out_ready && (replies_seen == 149 || replies_seen == 449)) begin
        hold_off_left <= HOLD_OFF_CYCLES;
      end
    end
  end

  // Monitor: compare each accepted reply with the oldest prediction, and drive
  // out_ready with random stalls plus the long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("reply with no request outstanding: read_value %0d status %0d occupancy %0d",
                 read_value, status, occupancy);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d", want.read_value, read_value);
            error_count++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            error_count++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occupancy);
            error_count++;
          end
        end
        replies_checked++;
      end
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty refusals, extremes of the word, front insert into an
    // empty deque (head wraps below zero), reserved codes, drain both ends.
    // Capacity stays at its reset value here.
    idle_on = 1'b0;
    queue_request(OP_POP_FRONT,  pick_word());
    queue_request(OP_POP_BACK,   pick_word());
    queue_request(OP_PEEK_FRONT, pick_word());
    queue_request(OP_PEEK_BACK,  pick_word());
    queue_request(OP_RESERVED_6, pick_word());
    queue_request(OP_PUSH_FRONT, 32'h8000_0000);
    queue_request(OP_PEEK_BACK,  pick_word());
    queue_request(OP_PUSH_BACK,  32'h7FFF_FFFF);
    queue_request(OP_PUSH_FRONT, 32'h0000_0000);
    queue_request(OP_PUSH_BACK,  32'hFFFF_FFFF);
    queue_request(OP_PEEK_FRONT, pick_word());
    queue_request(OP_PEEK_BACK,  pick_word());
    queue_request(OP_RESERVED_7, pick_word());
    queue_request(OP_POP_BACK,   pick_word());
    queue_request(OP_POP_FRONT,  pick_word());
    queue_request(OP_POP_FRONT,  pick_word());
    queue_request(OP_POP_BACK,   pick_word());
    queue_request(OP_POP_BACK,   pick_word());
    queue_request(OP_PUSH_BACK,  32'h5555_5555);
    queue_request(OP_POP_FRONT,  pick_word());
    queue_request(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    queue_request(OP_POP_BACK,   pick_word());

    // Zero capacity: every push refused as full
    set_capacity(0);
    queue_request(OP_PUSH_BACK,  pick_word());
    queue_request(OP_PUSH_FRONT, pick_word());
    queue_request(OP_PEEK_BACK,  pick_word());
    random_phase(0, 1'b1, 20, 60);

    // Capacity of one
    set_capacity(1);
    queue_request(OP_PUSH_BACK,  pick_word());
    queue_request(OP_PUSH_BACK,  pick_word());
    queue_request(OP_PUSH_FRONT, pick_word());
    queue_request(OP_PEEK_FRONT, pick_word());
    queue_request(OP_POP_BACK,   pick_word());
    queue_request(OP_PUSH_FRONT, pick_word());
    queue_request(OP_POP_FRONT,  pick_word());
    random_phase(1, 1'b1, 30, 50);

    // Lower the capacity under the current count: words stay, pushes refused
    set_capacity(QUEUE_DEPTH);
    repeat (12) queue_request(OP_PUSH_BACK, pick_word());
    random_phase(3, 1'b1, 40, 45);

    // Random mix across capacities; some phases run without any idling
    random_phase(2, 1'b1, 60, 55);
    random_phase(7, 1'b0, 60, 55);
    random_phase($urandom_range(1, 32), 1'b1, 60, 50);
    random_phase(16, 1'b1, 60, 60);
    random_phase(64, 1'b1, 60, 65);
    random_phase(1023, 1'b0, 60, 50);
    random_phase(QUEUE_DEPTH, 1'b1, 60, 40);
    random_phase($urandom_range(1, 32), 1'b1, 60, 55);

    // Capacity above the store depth: the depth becomes the limit
    random_phase(2047, 1'b1, 60, 60);

    wait_drained();
    if (error_count == 0) begin
      $display("PASS bounded_double_ended_queue_core");
    end else begin
      $display("FAIL bounded_double_ended_queue_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAIL bounded_double_ended_queue_core");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bounded_double_ended_queue_core.sv
tb/bounded_double_ended_queue_core_tb.sv
